### hdl/hrdp_pkg.sv
package hrdp_pkg;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SHORT,
      PH_LSIZE,
      PH_LTAG,
      PH_LSKIP
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MAIN,
      BK_USE,
      BK_RANGE,
      BK_TRUNC
   } back_state_type;

   localparam logic [3:0] EV_INPUT     = 4'd0;
   localparam logic [3:0] EV_OUTPUT    = 4'd1;
   localparam logic [3:0] EV_FEATURE   = 4'd2;
   localparam logic [3:0] EV_COLL      = 4'd3;
   localparam logic [3:0] EV_END_COLL  = 4'd4;
   localparam logic [3:0] EV_OTHER     = 4'd5;
   localparam logic [3:0] EV_USAGE     = 4'd6;
   localparam logic [3:0] EV_RANGE     = 4'd7;
   localparam logic [3:0] EV_TRUNC     = 4'd8;

   localparam logic [1:0] TYPE_MAIN    = 2'd0;
   localparam logic [1:0] TYPE_GLOBAL  = 2'd1;
   localparam logic [1:0] TYPE_LOCAL   = 2'd2;
   localparam logic [1:0] TYPE_RSVD    = 2'd3;

   localparam logic [3:0] TAG_INPUT    = 4'd8;
   localparam logic [3:0] TAG_OUTPUT   = 4'd9;
   localparam logic [3:0] TAG_COLL     = 4'd10;
   localparam logic [3:0] TAG_FEATURE  = 4'd11;
   localparam logic [3:0] TAG_END_COLL = 4'd12;
   localparam logic [3:0] TAG_UPAGE    = 4'd0;
   localparam logic [3:0] TAG_USAGE    = 4'd0;
   localparam logic [3:0] TAG_UMIN     = 4'd1;
   localparam logic [3:0] TAG_UMAX     = 4'd2;

   localparam logic [7:0] LONG_HEADER  = 8'hFE;
   localparam logic [7:0] DEPTH_MAX    = 8'd255;

   // global word slots
   localparam int GW_LMIN  = 0;
   localparam int GW_LMAX  = 1;
   localparam int GW_PMIN  = 2;
   localparam int GW_PMAX  = 3;
   localparam int GW_UEXP  = 4;
   localparam int GW_UNIT  = 5;
   localparam int GW_RSIZE = 6;
   localparam int GW_RID   = 7;
   localparam int GW_RCNT  = 8;
   localparam int GW_NUM   = 9;

   typedef struct packed {
      logic        item_vld;
      logic [7:0]  header;
      logic [31:0] data;
      logic        trunc;
      logic        fin;
   } job_type;

   typedef struct packed {
      logic [3:0]         event_kind;
      logic [31:0]        item_data;
      logic [31:0]        id_word;
      logic [31:0]        size_word;
      logic [31:0]        count_word;
      logic signed [31:0] lmin_word;
      logic signed [31:0] lmax_word;
      logic signed [31:0] pmin_word;
      logic signed [31:0] pmax_word;
      logic [31:0]        unit_word;
      logic [31:0]        aux_word;
      logic               last_result;
   } rec_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

### hdl/hrdp_if.sv
interface hrdp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] desc_byte;
   logic       final_byte;

   modport source (output valid, output desc_byte, output final_byte, input ready);
   modport sink (input valid, input desc_byte, input final_byte, output ready);
endinterface

interface hrdp_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         event_kind;
   logic [31:0]        item_data;
   logic [31:0]        id_word;
   logic [31:0]        size_word;
   logic [31:0]        count_word;
   logic signed [31:0] lmin_word;
   logic signed [31:0] lmax_word;
   logic signed [31:0] pmin_word;
   logic signed [31:0] pmax_word;
   logic [31:0]        unit_word;
   logic [31:0]        aux_word;
   logic               last_result;

   modport source (output valid, output event_kind, output item_data, output id_word,
                   output size_word, output count_word, output lmin_word,
                   output lmax_word, output pmin_word, output pmax_word,
                   output unit_word, output aux_word, output last_result, input ready);
   modport sink (input valid, input event_kind, input item_data, input id_word,
                 input size_word, input count_word, input lmin_word,
                 input lmax_word, input pmin_word, input pmax_word,
                 input unit_word, input aux_word, input last_result, output ready);
endinterface

### hdl/hrdp_front.sv
module hrdp_front (
   input  logic             clock,
   input  logic             reset,
   hrdp_req_if.sink         req_chan,
   input  logic             q_full,
   output logic             job_push,
   output hrdp_pkg::job_type job
);

   hrdp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  hdr_ff, hdr_in;
   logic [31:0] acc_ff, acc_in;
   logic [7:0]  rem_ff, rem_in;
   logic [1:0]  idx_ff, idx_in;
   logic        accept;
   logic        run;
   logic [7:0]  b;

   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && !q_full;
   assign b = req_chan.desc_byte;

   always_comb begin
      phase_in = phase_ff;
      hdr_in   = hdr_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      idx_in   = idx_ff;
      run      = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            hrdp_pkg::PH_HEADER: begin
               hdr_in = b;
               acc_in = '0;
               idx_in = '0;
               if (b == hrdp_pkg::LONG_HEADER) begin
                  phase_in = hrdp_pkg::PH_LSIZE;
               end else begin
                  rem_in = (b[1:0] == 2'd3) ? 8'd4 : {6'd0, b[1:0]};
                  if (b[1:0] == 2'd0) begin
                     run = 1'b1;
                  end else begin
                     phase_in = hrdp_pkg::PH_SHORT;
                  end
               end
            end
            hrdp_pkg::PH_SHORT: begin
               acc_in = acc_ff | (32'(b) << {idx_ff, 3'b000});
               idx_in = idx_ff + 2'd1;
               rem_in = rem_ff - 8'd1;
               if (rem_ff == 8'd1) begin
                  phase_in = hrdp_pkg::PH_HEADER;
                  run = 1'b1;
               end
            end
            hrdp_pkg::PH_LSIZE: begin
               rem_in   = b;
               phase_in = hrdp_pkg::PH_LTAG;
            end
            hrdp_pkg::PH_LTAG: begin
               phase_in = (rem_ff != 8'd0) ? hrdp_pkg::PH_LSKIP : hrdp_pkg::PH_HEADER;
            end
            hrdp_pkg::PH_LSKIP: begin
               rem_in = rem_ff - 8'd1;
               if (rem_ff == 8'd1) begin
                  phase_in = hrdp_pkg::PH_HEADER;
               end
            end
            default: phase_in = hrdp_pkg::PH_HEADER;
         endcase
      end
      job.item_vld = run;
      job.header   = hdr_in;
      job.data     = acc_in;
      job.fin      = req_chan.final_byte;
      job.trunc    = req_chan.final_byte && (phase_in != hrdp_pkg::PH_HEADER);
      job_push     = accept && (run || req_chan.final_byte);
      if (accept && req_chan.final_byte) begin
         phase_in = hrdp_pkg::PH_HEADER;
         hdr_in   = '0;
         acc_in   = '0;
         rem_in   = '0;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hrdp_pkg::PH_HEADER;
         hdr_ff   <= '0;
         acc_ff   <= '0;
         rem_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         hdr_ff   <= hdr_in;
         acc_ff   <= acc_in;
         rem_ff   <= rem_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

### hdl/hrdp_queue.sv
module hrdp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hrdp_pkg::job_type      push_job,
   input  logic                   pop,
   output hrdp_pkg::job_type      pop_job,
   output hrdp_pkg::q_status_type status
);

   hrdp_pkg::job_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hdl/hrdp_back.sv
module hrdp_back #(
   parameter int MAX_USAGES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  hrdp_pkg::job_type job,
   output logic              job_pop,
   hrdp_rsp_if.source        rsp_chan
);

   localparam int IW = (MAX_USAGES > 1) ? $clog2(MAX_USAGES) : 1;
   localparam int CW = $clog2(MAX_USAGES + 1);

   hrdp_pkg::back_state_type state_ff, state_in;
   hrdp_pkg::job_type job_ff, job_in;
   hrdp_pkg::rec_type rec_ff, rec_in;
   logic        rv_ff, rv_in;
   logic [31:0] gw_ff [hrdp_pkg::GW_NUM];
   logic [31:0] gw_in [hrdp_pkg::GW_NUM];
   logic [31:0] upage_ff, upage_in;
   logic [31:0] rlo_ff, rlo_in;
   logic [31:0] rhi_ff, rhi_in;
   logic [7:0]  depth_ff, depth_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [31:0] mem [MAX_USAGES];
   logic [31:0] rd_data_ff;
   logic        wr_en;
   logic [IW-1:0] wr_addr;
   logic        can_emit;
   logic        finish;
   logic        clear_all;
   logic [1:0]  q_type;
   logic [3:0]  q_tag;
   logic [31:0] q_s;
   logic [3:0]  m_tag;
   logic        m_field;
   logic        m_coll;
   logic        has_use;
   logic        has_rng;
   logic        last_use;
   logic [7:0]  depth_dec;

   assign can_emit  = !rv_ff || rsp_chan.ready;
   assign q_type    = job.header[3:2];
   assign q_tag     = job.header[7:4];
   assign m_tag     = job_ff.header[7:4];
   assign m_field   = (m_tag == hrdp_pkg::TAG_INPUT) || (m_tag == hrdp_pkg::TAG_OUTPUT)
                      || (m_tag == hrdp_pkg::TAG_FEATURE);
   assign m_coll    = (m_tag == hrdp_pkg::TAG_COLL);
   assign has_use   = (m_field || m_coll) && (fill_ff != '0);
   assign has_rng   = m_field && (fill_ff == '0) && ((rlo_ff | rhi_ff) != '0);
   assign last_use  = (CW'(idx_ff) + CW'(1)) == fill_ff;
   assign depth_dec = (depth_ff != 8'd0) ? depth_ff - 8'd1 : 8'd0;

   always_comb begin
      q_s = job.data;
      if (job.header[1:0] == 2'd1 && job.data[7]) begin
         q_s = job.data | 32'hFFFF_FF00;
      end else if (job.header[1:0] == 2'd2 && job.data[15]) begin
         q_s = job.data | 32'hFFFF_0000;
      end
   end

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      rec_in    = rec_ff;
      rv_in     = rv_ff && !rsp_chan.ready;
      gw_in     = gw_ff;
      upage_in  = upage_ff;
      rlo_in    = rlo_ff;
      rhi_in    = rhi_ff;
      depth_in  = depth_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      job_pop   = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = fill_ff[IW-1:0];
      finish    = 1'b0;
      clear_all = 1'b0;
      unique case (state_ff)
         hrdp_pkg::BK_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               job_in  = job;
               if (job.item_vld && q_type == hrdp_pkg::TYPE_MAIN) begin
                  state_in = hrdp_pkg::BK_MAIN;
               end else begin
                  if (job.item_vld && q_type == hrdp_pkg::TYPE_GLOBAL) begin
                     if (q_tag == hrdp_pkg::TAG_UPAGE) begin
                        upage_in = job.data;
                     end else if (q_tag <= 4'd4) begin
                        gw_in[q_tag - 4'd1] = q_s;
                     end else if (q_tag <= 4'd9) begin
                        gw_in[q_tag - 4'd1] = job.data;
                     end
                  end
                  if (job.item_vld && q_type == hrdp_pkg::TYPE_LOCAL) begin
                     if (q_tag == hrdp_pkg::TAG_USAGE) begin
                        if (fill_ff < CW'(MAX_USAGES)) begin
                           wr_en   = 1'b1;
                           fill_in = fill_ff + CW'(1);
                        end
                     end else if (q_tag == hrdp_pkg::TAG_UMIN) begin
                        rlo_in = job.data;
                     end else if (q_tag == hrdp_pkg::TAG_UMAX) begin
                        rhi_in = job.data;
                     end
                  end
                  if (job.trunc) begin
                     state_in = hrdp_pkg::BK_TRUNC;
                  end else if (job.fin) begin
                     clear_all = 1'b1;
                  end
               end
            end
         end
         hrdp_pkg::BK_MAIN: begin
            if (can_emit) begin
               rv_in  = 1'b1;
               rec_in = '0;
               rec_in.item_data = job_ff.data;
               if (m_field) begin
                  rec_in.event_kind = (m_tag == hrdp_pkg::TAG_INPUT)  ? hrdp_pkg::EV_INPUT :
                                      (m_tag == hrdp_pkg::TAG_OUTPUT) ? hrdp_pkg::EV_OUTPUT :
                                      hrdp_pkg::EV_FEATURE;
                  rec_in.id_word    = gw_ff[hrdp_pkg::GW_RID];
                  rec_in.size_word  = gw_ff[hrdp_pkg::GW_RSIZE];
                  rec_in.count_word = gw_ff[hrdp_pkg::GW_RCNT];
                  rec_in.lmin_word  = gw_ff[hrdp_pkg::GW_LMIN];
                  rec_in.lmax_word  = gw_ff[hrdp_pkg::GW_LMAX];
                  rec_in.pmin_word  = gw_ff[hrdp_pkg::GW_PMIN];
                  rec_in.pmax_word  = gw_ff[hrdp_pkg::GW_PMAX];
                  rec_in.unit_word  = gw_ff[hrdp_pkg::GW_UNIT];
                  rec_in.aux_word   = gw_ff[hrdp_pkg::GW_UEXP];
               end else if (m_coll) begin
                  rec_in.event_kind = hrdp_pkg::EV_COLL;
                  rec_in.aux_word   = {24'd0, depth_ff};
               end else if (m_tag == hrdp_pkg::TAG_END_COLL) begin
                  rec_in.event_kind = hrdp_pkg::EV_END_COLL;
                  rec_in.item_data  = '0;
                  rec_in.aux_word   = {24'd0, depth_dec};
               end else begin
                  rec_in.event_kind = hrdp_pkg::EV_OTHER;
               end
               rec_in.last_result = !has_use && !has_rng && !job_ff.trunc;
               if (has_use) begin
                  state_in = hrdp_pkg::BK_USE;
                  idx_in   = '0;
               end else if (has_rng) begin
                  state_in = hrdp_pkg::BK_RANGE;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         hrdp_pkg::BK_USE: begin
            if (can_emit) begin
               rv_in  = 1'b1;
               rec_in = '0;
               rec_in.event_kind  = hrdp_pkg::EV_USAGE;
               rec_in.unit_word   = upage_ff;
               rec_in.aux_word    = rd_data_ff;
               rec_in.last_result = last_use && !job_ff.trunc;
               if (last_use) begin
                  finish = 1'b1;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         hrdp_pkg::BK_RANGE: begin
            if (can_emit) begin
               rv_in  = 1'b1;
               rec_in = '0;
               rec_in.event_kind  = hrdp_pkg::EV_RANGE;
               rec_in.item_data   = upage_ff;
               rec_in.unit_word   = rlo_ff;
               rec_in.aux_word    = rhi_ff;
               rec_in.last_result = !job_ff.trunc;
               finish = 1'b1;
            end
         end
         hrdp_pkg::BK_TRUNC: begin
            if (can_emit) begin
               rv_in  = 1'b1;
               rec_in = '0;
               rec_in.event_kind  = hrdp_pkg::EV_TRUNC;
               rec_in.item_data   = {24'd0, job_ff.header};
               rec_in.last_result = 1'b1;
               clear_all = 1'b1;
               state_in  = hrdp_pkg::BK_IDLE;
            end
         end
         default: state_in = hrdp_pkg::BK_IDLE;
      endcase

      if (finish) begin
         fill_in = '0;
         rlo_in  = '0;
         rhi_in  = '0;
         if (m_coll && depth_ff != hrdp_pkg::DEPTH_MAX) begin
            depth_in = depth_ff + 8'd1;
         end else if (m_tag == hrdp_pkg::TAG_END_COLL) begin
            depth_in = depth_dec;
         end
         if (job_ff.trunc) begin
            state_in = hrdp_pkg::BK_TRUNC;
         end else begin
            state_in  = hrdp_pkg::BK_IDLE;
            clear_all = job_ff.fin;
         end
      end

      if (clear_all) begin
         for (int i = 0; i < hrdp_pkg::GW_NUM; i++) begin
            gw_in[i] = '0;
         end
         upage_in = '0;
         rlo_in   = '0;
         rhi_in   = '0;
         depth_in = '0;
         fill_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= job.data;
      end
      rd_data_ff <= mem[idx_in];
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      job_ff <= job_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrdp_pkg::BK_IDLE;
         rv_ff    <= 1'b0;
         for (int i = 0; i < hrdp_pkg::GW_NUM; i++) begin
            gw_ff[i] <= '0;
         end
         upage_ff <= '0;
         rlo_ff   <= '0;
         rhi_ff   <= '0;
         depth_ff <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         gw_ff    <= gw_in;
         upage_ff <= upage_in;
         rlo_ff   <= rlo_in;
         rhi_ff   <= rhi_in;
         depth_ff <= depth_in;
         fill_ff  <= fill_in;
      end
   end

   assign rsp_chan.valid       = rv_ff;
   assign rsp_chan.event_kind  = rec_ff.event_kind;
   assign rsp_chan.item_data   = rec_ff.item_data;
   assign rsp_chan.id_word     = rec_ff.id_word;
   assign rsp_chan.size_word   = rec_ff.size_word;
   assign rsp_chan.count_word  = rec_ff.count_word;
   assign rsp_chan.lmin_word   = rec_ff.lmin_word;
   assign rsp_chan.lmax_word   = rec_ff.lmax_word;
   assign rsp_chan.pmin_word   = rec_ff.pmin_word;
   assign rsp_chan.pmax_word   = rec_ff.pmax_word;
   assign rsp_chan.unit_word   = rec_ff.unit_word;
   assign rsp_chan.aux_word    = rec_ff.aux_word;
   assign rsp_chan.last_result = rec_ff.last_result;

endmodule

### hdl/hid_report_descriptor_parser_unit.sv
// An item's last byte is queued, popped into the job register, then registered as a record.
// Throughput: one byte per cycle while the 2-entry item queue has room; the back end
// emits one record at a time (main record, then one per usage, range or truncation),
// and holds each record until the receiver takes it.
// Reset (synchronous): parser, globals, usage count, depth and queue clear; usage list is not.
module hid_report_descriptor_parser_unit #(
   parameter int MAX_USAGES = 16
) (
   input  logic      clock,
   input  logic      reset,
   hrdp_req_if.sink  req_chan,
   hrdp_rsp_if.source rsp_chan
);

   hrdp_pkg::job_type      push_job;
   hrdp_pkg::job_type      pop_job;
   hrdp_pkg::q_status_type q_status;
   logic                   push;
   logic                   pop;

   hrdp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_status.full),
      .job_push (push),
      .job      (push_job)
   );

   hrdp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .status   (q_status)
   );

   hrdp_back #(
      .MAX_USAGES (MAX_USAGES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!q_status.empty),
      .job       (pop_job),
      .job_pop   (pop),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTHESIS
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result valid after reset");
   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.event_kind == hrdp_pkg::EV_TRUNC |-> rsp_chan.last_result)
      else $error("truncation record not last");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !req_chan.ready)
      else $error("byte taken while queue full");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty || !pop)
      else $error("pop of empty queue");
`endif

endmodule

### tb/hid_report_descriptor_parser_unit_test.sv
module hid_report_descriptor_parser_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_USAGES = 16;

   typedef struct {
      logic [7:0] desc_byte;
      logic       final_byte;
      logic       typed;
      logic [3:0] kind;
      logic [31:0] data;
      logic [31:0] aux;
   } byte_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hrdp_req_if req_chan ();
   hrdp_rsp_if rsp_chan ();

   hid_report_descriptor_parser_unit #(.MAX_USAGES(MAX_USAGES)) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always #6 clock = ~clock;

   byte_row_type      desc_q[$];
   hrdp_pkg::rec_type record_q[$];
   int                sent_pos = 0;
   int                errors = 0;
   int                rsp_seen = 0;

   // shadow parser state
   hrdp_pkg::phase_type sh_phase;
   logic [7:0]  sh_header;
   logic [31:0] sh_acc;
   logic [7:0]  sh_remain;
   logic [1:0]  sh_idx;
   logic [31:0] sh_upage;
   logic [31:0] sh_glob [hrdp_pkg::GW_NUM];
   logic [31:0] sh_usages [MAX_USAGES];
   int          sh_fill;
   logic [31:0] sh_rlow, sh_rhigh;
   logic [7:0]  sh_depth;

   task automatic shadow_reset();
      sh_phase = hrdp_pkg::PH_HEADER;
      sh_header = '0;
      sh_acc = '0;
      sh_remain = '0;
      sh_idx = '0;
      sh_upage = '0;
      for (int i = 0; i < hrdp_pkg::GW_NUM; i++) sh_glob[i] = '0;
      sh_fill = 0;
      sh_rlow = '0;
      sh_rhigh = '0;
      sh_depth = '0;
   endtask

   task automatic push_record(logic [3:0] kind, logic [31:0] data, logic [31:0] unitw,
                              logic [31:0] aux, bit with_globals);
      hrdp_pkg::rec_type r;
      r = '0;
      r.event_kind = kind;
      r.item_data = data;
      if (with_globals) begin
         r.id_word = sh_glob[hrdp_pkg::GW_RID];
         r.size_word = sh_glob[hrdp_pkg::GW_RSIZE];
         r.count_word = sh_glob[hrdp_pkg::GW_RCNT];
         r.lmin_word = sh_glob[hrdp_pkg::GW_LMIN];
         r.lmax_word = sh_glob[hrdp_pkg::GW_LMAX];
         r.pmin_word = sh_glob[hrdp_pkg::GW_PMIN];
         r.pmax_word = sh_glob[hrdp_pkg::GW_PMAX];
      end
      r.unit_word = unitw;
      r.aux_word = aux;
      record_q.push_back(r);
   endtask

   task automatic push_usages();
      for (int k = 0; k < sh_fill; k++)
         push_record(hrdp_pkg::EV_USAGE, '0, sh_upage, sh_usages[k], 1'b0);
   endtask

   task automatic execute_item();
      logic [1:0]  sz;
      logic [1:0]  ityp;
      logic [3:0]  tag;
      logic [31:0] sx;
      logic [3:0]  kind;
      sz = sh_header[1:0];
      ityp = sh_header[3:2];
      tag = sh_header[7:4];
      sx = sh_acc;
      if (sz == 2'd1 && sh_acc[7]) sx = sh_acc | 32'hFFFF_FF00;
      if (sz == 2'd2 && sh_acc[15]) sx = sh_acc | 32'hFFFF_0000;
      if (ityp == hrdp_pkg::TYPE_MAIN) begin
         if (tag == hrdp_pkg::TAG_INPUT || tag == hrdp_pkg::TAG_OUTPUT
             || tag == hrdp_pkg::TAG_FEATURE) begin
            kind = (tag == hrdp_pkg::TAG_INPUT) ? hrdp_pkg::EV_INPUT :
                   (tag == hrdp_pkg::TAG_OUTPUT) ? hrdp_pkg::EV_OUTPUT : hrdp_pkg::EV_FEATURE;
            push_record(kind, sh_acc, sh_glob[hrdp_pkg::GW_UNIT],
                        sh_glob[hrdp_pkg::GW_UEXP], 1'b1);
            if (sh_fill > 0) push_usages();
            else if (sh_rlow != 0 || sh_rhigh != 0)
               push_record(hrdp_pkg::EV_RANGE, sh_upage, sh_rlow, sh_rhigh, 1'b0);
         end else if (tag == hrdp_pkg::TAG_COLL) begin
            push_record(hrdp_pkg::EV_COLL, sh_acc, '0, {24'd0, sh_depth}, 1'b0);
            push_usages();
            if (sh_depth != hrdp_pkg::DEPTH_MAX) sh_depth++;
         end else if (tag == hrdp_pkg::TAG_END_COLL) begin
            if (sh_depth != 0) sh_depth--;
            push_record(hrdp_pkg::EV_END_COLL, '0, '0, {24'd0, sh_depth}, 1'b0);
         end else begin
            push_record(hrdp_pkg::EV_OTHER, sh_acc, '0, '0, 1'b0);
         end
         sh_fill = 0;
         sh_rlow = '0;
         sh_rhigh = '0;
      end else if (ityp == hrdp_pkg::TYPE_GLOBAL) begin
         if (tag == hrdp_pkg::TAG_UPAGE) sh_upage = sh_acc;
         else if (tag >= 1 && tag <= 4) sh_glob[tag - 1] = sx;
         else if (tag >= 5 && tag <= 9) sh_glob[tag - 1] = sh_acc;
      end else if (ityp == hrdp_pkg::TYPE_LOCAL) begin
         if (tag == hrdp_pkg::TAG_USAGE) begin
            if (sh_fill < MAX_USAGES) begin
               sh_usages[sh_fill] = sh_acc;
               sh_fill++;
            end
         end else if (tag == hrdp_pkg::TAG_UMIN) sh_rlow = sh_acc;
         else if (tag == hrdp_pkg::TAG_UMAX) sh_rhigh = sh_acc;
      end
   endtask

   task automatic predict_byte(byte_row_type row);
      int first;
      first = record_q.size();
      case (sh_phase)
         hrdp_pkg::PH_HEADER: begin
            sh_header = row.desc_byte;
            sh_acc = '0;
            sh_idx = '0;
            if (row.desc_byte == hrdp_pkg::LONG_HEADER) sh_phase = hrdp_pkg::PH_LSIZE;
            else begin
               sh_remain = (row.desc_byte[1:0] == 2'd3) ? 8'd4 : {6'd0, row.desc_byte[1:0]};
               if (sh_remain == 0) execute_item();
               else sh_phase = hrdp_pkg::PH_SHORT;
            end
         end
         hrdp_pkg::PH_SHORT: begin
            sh_acc = sh_acc | (32'(row.desc_byte) << (8 * sh_idx));
            sh_idx = sh_idx + 2'd1;
            if (sh_remain != 0) sh_remain--;
            if (sh_remain == 0) begin
               sh_phase = hrdp_pkg::PH_HEADER;
               execute_item();
            end
         end
         hrdp_pkg::PH_LSIZE: begin
            sh_remain = row.desc_byte;
            sh_phase = hrdp_pkg::PH_LTAG;
         end
         hrdp_pkg::PH_LTAG:
            sh_phase = (sh_remain != 0) ? hrdp_pkg::PH_LSKIP : hrdp_pkg::PH_HEADER;
         default: begin
            if (sh_remain != 0) sh_remain--;
            if (sh_remain == 0) sh_phase = hrdp_pkg::PH_HEADER;
         end
      endcase
      if (row.final_byte) begin
         if (sh_phase != hrdp_pkg::PH_HEADER)
            push_record(hrdp_pkg::EV_TRUNC, {24'd0, sh_header}, '0, '0, 1'b0);
         shadow_reset();
      end
      if (record_q.size() > first) begin
         record_q[record_q.size() - 1].last_result = 1'b1;
         if (row.typed) begin
            record_q[first].event_kind = row.kind;
            record_q[first].item_data = row.data;
            record_q[first].aux_word = row.aux;
         end
      end
   endtask

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on record %0d: %s got %h expected %h", rsp_seen, field, got, want);
      errors++;
   endtask

   task automatic check_record(hrdp_pkg::rec_type got);
      hrdp_pkg::rec_type want;
      if (record_q.size() == 0) begin
         report_mismatch("unexpected record", 32'(got.event_kind), '0);
         return;
      end
      want = record_q.pop_front();
      if (got.event_kind !== want.event_kind)
         report_mismatch("event_kind", 32'(got.event_kind), 32'(want.event_kind));
      if (got.item_data !== want.item_data)
         report_mismatch("item_data", got.item_data, want.item_data);
      if (got.id_word !== want.id_word) report_mismatch("id_word", got.id_word, want.id_word);
      if (got.size_word !== want.size_word)
         report_mismatch("size_word", got.size_word, want.size_word);
      if (got.count_word !== want.count_word)
         report_mismatch("count_word", got.count_word, want.count_word);
      if (got.lmin_word !== want.lmin_word)
         report_mismatch("lmin_word", got.lmin_word, want.lmin_word);
      if (got.lmax_word !== want.lmax_word)
         report_mismatch("lmax_word", got.lmax_word, want.lmax_word);
      if (got.pmin_word !== want.pmin_word)
         report_mismatch("pmin_word", got.pmin_word, want.pmin_word);
      if (got.pmax_word !== want.pmax_word)
         report_mismatch("pmax_word", got.pmax_word, want.pmax_word);
      if (got.unit_word !== want.unit_word)
         report_mismatch("unit_word", got.unit_word, want.unit_word);
      if (got.aux_word !== want.aux_word)
         report_mismatch("aux_word", got.aux_word, want.aux_word);
      if (got.last_result !== want.last_result)
         report_mismatch("last_result", 32'(got.last_result), 32'(want.last_result));
   endtask

   task automatic add_byte(logic [7:0] b, logic fin);
      byte_row_type row;
      row = '{b, fin, 1'b0, 4'd0, 32'd0, 32'd0};
      desc_q.push_back(row);
   endtask

   // one short item with random payload; a cut item stops one data byte short
   task automatic add_item(logic [3:0] tag, logic [1:0] ityp, logic [1:0] sz, bit cut);
      int n;
      n = (sz == 2'd3) ? 4 : int'(sz);
      add_byte({tag, ityp, sz}, 1'b0);
      for (int i = 0; i < n; i++) begin
         if (cut && i == n - 1) break;
         add_byte(8'($urandom), 1'b0);
      end
      if (cut) desc_q[desc_q.size() - 1].final_byte = 1'b1;
   endtask

   task automatic add_random_descriptor(int items);
      int sel;
      int len;
      logic [3:0] mains [3];
      mains = '{hrdp_pkg::TAG_INPUT, hrdp_pkg::TAG_OUTPUT, hrdp_pkg::TAG_FEATURE};
      for (int it = 0; it < items; it++) begin
         sel = $urandom_range(0, 99);
         if (sel < 22)
            add_item(mains[$urandom_range(0, 2)], hrdp_pkg::TYPE_MAIN, 2'($urandom), 1'b0);
         else if (sel < 30)
            add_item(hrdp_pkg::TAG_COLL, hrdp_pkg::TYPE_MAIN, 2'($urandom_range(0, 1)), 1'b0);
         else if (sel < 38)
            add_item(hrdp_pkg::TAG_END_COLL, hrdp_pkg::TYPE_MAIN, 2'd0, 1'b0);
         else if (sel < 62)
            add_item(4'($urandom), hrdp_pkg::TYPE_GLOBAL, 2'($urandom), 1'b0);
         else if (sel < 85)
            add_item(4'($urandom_range(0, 3)), hrdp_pkg::TYPE_LOCAL, 2'($urandom), 1'b0);
         else if (sel < 88) begin
            for (int u = 0; u < 18; u++)
               add_item(hrdp_pkg::TAG_USAGE, hrdp_pkg::TYPE_LOCAL, 2'd1, 1'b0);
         end else if (sel < 92) begin
            len = $urandom_range(0, 5);
            add_byte(hrdp_pkg::LONG_HEADER, 1'b0);
            add_byte(8'(len), 1'b0);
            add_byte(8'($urandom), 1'b0);
            for (int k = 0; k < len; k++) add_byte(8'($urandom), 1'b0);
         end else if (sel < 96)
            add_item(4'($urandom), hrdp_pkg::TYPE_RSVD, 2'($urandom), 1'b0);
         else add_byte(8'($urandom), 1'b0);
      end
      sel = $urandom_range(0, 9);
      if (sel < 2) add_item(4'($urandom), 2'($urandom), 2'($urandom_range(1, 3)), 1'b1);
      else if (sel < 3) begin
         add_byte(hrdp_pkg::LONG_HEADER, 1'b0);
         add_byte(8'd3, 1'b1);
      end else add_item(mains[$urandom_range(0, 2)], hrdp_pkg::TYPE_MAIN, 2'($urandom), 1'b0);
      desc_q[desc_q.size() - 1].final_byte = 1'b1;
   endtask

   task automatic build_stimulus();
      byte_row_type directed [28] = '{
         '{8'h80, 1'b0, 1'b1, hrdp_pkg::EV_INPUT, 32'h0, 32'h0},
         '{8'hC0, 1'b0, 1'b1, hrdp_pkg::EV_END_COLL, 32'h0, 32'h0},
         '{8'h05, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'h01, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'h09, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'h30, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'hA1, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'h01, 1'b0, 1'b1, hrdp_pkg::EV_COLL, 32'h1, 32'h0},
         '{8'h15, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'h80, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'h27, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'hFF, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'hFF, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'hFF, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'hFF, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'hA4, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'h19, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'h01, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'h91, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'hFF, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'hF0, 1'b0, 1'b1, hrdp_pkg::EV_OTHER, 32'h0, 32'h0},
         '{8'hFE, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'h01, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'h10, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'hAA, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'h0C, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'h26, 1'b0, 1'b0, 4'd0, 32'h0, 32'h0},
         '{8'h34, 1'b1, 1'b1, hrdp_pkg::EV_TRUNC, 32'h26, 32'h0}
      };
      foreach (directed[i]) desc_q.push_back(directed[i]);
      for (int d = 0; d < 258; d++) add_byte(8'hA0, 1'b0);
      add_byte(8'h80, 1'b0);
      add_byte(8'hC0, 1'b0);
      add_byte(8'hC0, 1'b1);
      while (desc_q.size() < 400) add_random_descriptor($urandom_range(3, 30));
   endtask

   // sender: bursts and gaps
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.desc_byte <= '0;
         req_chan.final_byte <= 1'b0;
      end else begin
         logic hold;
         hold = req_chan.valid && !req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            predict_byte(desc_q[sent_pos]);
            sent_pos++;
         end
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (sent_pos < desc_q.size()) begin
               req_chan.valid <= 1'b1;
               req_chan.desc_byte <= desc_q[sent_pos].desc_byte;
               req_chan.final_byte <= desc_q[sent_pos].final_byte;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: mode changes, plus one long hold-off
   int mode_left = 0;
   int rx_mode = 0;
   int hold_left = 0;
   bit held = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         hrdp_pkg::rec_type got;
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.event_kind = rsp_chan.event_kind;
            got.item_data = rsp_chan.item_data;
            got.id_word = rsp_chan.id_word;
            got.size_word = rsp_chan.size_word;
            got.count_word = rsp_chan.count_word;
            got.lmin_word = rsp_chan.lmin_word;
            got.lmax_word = rsp_chan.lmax_word;
            got.pmin_word = rsp_chan.pmin_word;
            got.pmax_word = rsp_chan.pmax_word;
            got.unit_word = rsp_chan.unit_word;
            got.aux_word = rsp_chan.aux_word;
            got.last_result = rsp_chan.last_result;
            check_record(got);
            rsp_seen++;
         end
         if (!held && rsp_seen >= 150) begin
            held = 1;
            hold_left = 400;
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(16, 96);
            rx_mode = $urandom_range(0, 2);
         end else mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (rx_mode == 0) rsp_chan.ready <= 1'b1;
         else if (rx_mode == 1) rsp_chan.ready <= ($urandom_range(0, 3) != 0);
         else rsp_chan.ready <= ($urandom_range(0, 3) == 0);
      end
   end

   initial begin
      shadow_reset();
      build_stimulus();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (sent_pos == desc_q.size() && record_q.size() == 0);
      repeat (30) @(posedge clock);
      if (errors == 0 && record_q.size() == 0) $display("[hid_report_descriptor_parser_unit] OK");
      else $display("[hid_report_descriptor_parser_unit] ERROR");
      $finish;
   end

   initial begin
      #10ms;
      $display("[hid_report_descriptor_parser_unit] ERROR");
      $finish;
   end

endmodule
